/* rtl/dtm_pkg.sv */
// ----------------------------------------------------------------------------
// dtm_pkg - shared types and constants of the divider/timer block
// Operation codes, register addresses, request and result structs, and the
// counter tap selector.
// ----------------------------------------------------------------------------
package dtm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  localparam logic [15:0] ADDR_DIV  = 16'hFF04;
  localparam logic [15:0] ADDR_TIMA = 16'hFF05;
  localparam logic [15:0] ADDR_TMA  = 16'hFF06;
  localparam logic [15:0] ADDR_TAC  = 16'hFF07;

  localparam logic [7:0] TAC_READ_ONES = 8'hF8;
  localparam logic [7:0] IDLE_READ     = 8'hFF;
  localparam logic [2:0] WINDOW_TICKS  = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } res_t;

  // TAC[1:0] = 0,1,2,3 picks counter bit 9, 3, 5 or 7
  function automatic logic tap_bit(input logic [15:0] counter, input logic [1:0] sel);
    logic b;
    case (sel)
      2'd0:    b = counter[9];
      2'd1:    b = counter[3];
      2'd2:    b = counter[5];
      default: b = counter[7];
    endcase
    return b;
  endfunction

endpackage

/* rtl/divider_timer_with_modulo_reload.sv */
// ----------------------------------------------------------------------------
// divider_timer_with_modulo_reload - DIV/TIMA/TMA/TAC timer block
// Request register, timer state update and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): each request is a clock tick, a bus
//   read or a bus write (operation, address, write_data). A request is taken
//   on a rising edge with in_valid high and in_stall low.
//   Output channel (out_valid/out_stall): exactly one result per request,
//   read_data (register byte on a read, 0xFF otherwise) and timer_irq (high on
//   the tick that reloads TIMA from TMA).
//   Path: request register then result register. The timer
//   state is updated in the same cycle the request moves into the result
//   register, one request per cycle while out_stall stays low.
//   Throughput: one request per cycle while out_stall stays low.
//   Stall: when the result waits, one more request is still taken into the
//   request register; in_stall rises only once both registers are full.
//   Reset (rst, synchronous): clears all timer state and empties both
//   registers; no pass is needed afterward.
// ----------------------------------------------------------------------------
module divider_timer_with_modulo_reload (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        timer_irq
);

  logic          req_valid;
  dtm_pkg::req_t req;
  dtm_pkg::res_t res;
  logic          advance;
  logic          accept;

  // request moves on whenever the result register is empty or draining
  assign advance  = req_valid && !(out_valid && out_stall);
  assign in_stall = req_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req.operation  <= operation;
      req.address    <= address;
      req.write_data <= write_data;
    end
  end

  dtm_timer u_timer (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data <= res.read_data;
      timer_irq <= res.timer_irq;
    end
  end

endmodule

/* rtl/dtm_timer.sv */
// ----------------------------------------------------------------------------
// dtm_timer - timer state and single-pass request update
// Holds DIV counter, TIMA, TMA, TAC and the overflow/reload sequencing.
// The result of a request is combinational; state commits when step is high.
// ----------------------------------------------------------------------------
module dtm_timer (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  dtm_pkg::req_t req,
  output dtm_pkg::res_t res
);

  logic [15:0] system_counter, system_counter_next;
  logic [7:0]  timer_count, timer_count_next;
  logic [7:0]  timer_modulo, timer_modulo_next;
  logic [2:0]  timer_control, timer_control_next;
  logic        previous_selected_bit, previous_selected_bit_next;
  logic        reload_pending, reload_pending_next;
  logic [2:0]  ticks_since_overflow, ticks_since_overflow_next;
  logic        reload_window_active, reload_window_active_next;
  logic [2:0]  ticks_after_reload, ticks_after_reload_next;

  always_comb begin
    logic       now;
    logic       old_sel;
    logic       bump;
    logic [7:0] bumped;
    system_counter_next        = system_counter;
    timer_count_next           = timer_count;
    timer_modulo_next          = timer_modulo;
    timer_control_next         = timer_control;
    previous_selected_bit_next = previous_selected_bit;
    reload_pending_next        = reload_pending;
    ticks_since_overflow_next  = ticks_since_overflow;
    reload_window_active_next  = reload_window_active;
    ticks_after_reload_next    = ticks_after_reload;
    res.read_data              = dtm_pkg::IDLE_READ;
    res.timer_irq              = 1'b0;
    now                        = 1'b0;
    old_sel                    = previous_selected_bit;
    bump                       = 1'b0;

    case (dtm_pkg::op_t'(req.operation))
      dtm_pkg::OP_TICK: begin
        if (reload_window_active) begin
          ticks_after_reload_next = ticks_after_reload + 3'd1;
          if (ticks_after_reload_next == dtm_pkg::WINDOW_TICKS)
            reload_window_active_next = 1'b0;
        end
        if (reload_pending) begin
          ticks_since_overflow_next = ticks_since_overflow + 3'd1;
          if (ticks_since_overflow_next == dtm_pkg::WINDOW_TICKS) begin
            timer_count_next          = timer_modulo;
            reload_pending_next       = 1'b0;
            res.timer_irq             = 1'b1;
            reload_window_active_next = 1'b1;
            ticks_after_reload_next   = 3'd0;
          end
        end
        system_counter_next = system_counter + 16'd1;
        now  = dtm_pkg::tap_bit(system_counter_next, timer_control[1:0]) & timer_control[2];
        bump = old_sel & ~now;
        previous_selected_bit_next = now;
      end
      dtm_pkg::OP_READ: begin
        case (req.address)
          dtm_pkg::ADDR_DIV:  res.read_data = system_counter[15:8];
          dtm_pkg::ADDR_TIMA: res.read_data = timer_count;
          dtm_pkg::ADDR_TMA:  res.read_data = timer_modulo;
          dtm_pkg::ADDR_TAC:  res.read_data = {5'd0, timer_control} | dtm_pkg::TAC_READ_ONES;
          default:            res.read_data = dtm_pkg::IDLE_READ;
        endcase
      end
      dtm_pkg::OP_WRITE: begin
        case (req.address)
          dtm_pkg::ADDR_DIV: begin
            system_counter_next = 16'd0;
            // cleared counter reads zero on every tap
            bump = old_sel;
            previous_selected_bit_next = 1'b0;
          end
          dtm_pkg::ADDR_TIMA: begin
            if (!reload_window_active) begin
              timer_count_next          = req.write_data;
              reload_pending_next       = 1'b0;
              ticks_since_overflow_next = 3'd0;
            end
          end
          dtm_pkg::ADDR_TMA: begin
            timer_modulo_next = req.write_data;
            if (reload_window_active)
              timer_count_next = req.write_data;
          end
          dtm_pkg::ADDR_TAC: begin
            now  = old_sel & req.write_data[2];
            // falling edge from disable, or rising-side glitch onto a set tap
            bump = (old_sel & ~now) |
                   (~old_sel & req.write_data[2] &
                    dtm_pkg::tap_bit(system_counter, req.write_data[1:0]));
            previous_selected_bit_next = now;
            timer_control_next = req.write_data[2:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    bumped = timer_count_next + 8'd1;
    if (bump) begin
      timer_count_next = bumped;
      if (bumped == 8'd0) begin
        reload_pending_next       = 1'b1;
        ticks_since_overflow_next = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      system_counter        <= '0;
      timer_count           <= '0;
      timer_modulo          <= '0;
      timer_control         <= '0;
      previous_selected_bit <= 1'b0;
      reload_pending        <= 1'b0;
      ticks_since_overflow  <= '0;
      reload_window_active  <= 1'b0;
      ticks_after_reload    <= '0;
    end else if (step) begin
      system_counter        <= system_counter_next;
      timer_count           <= timer_count_next;
      timer_modulo          <= timer_modulo_next;
      timer_control         <= timer_control_next;
      previous_selected_bit <= previous_selected_bit_next;
      reload_pending        <= reload_pending_next;
      ticks_since_overflow  <= ticks_since_overflow_next;
      reload_window_active  <= reload_window_active_next;
      ticks_after_reload    <= ticks_after_reload_next;
    end
  end

  a_irq_opens_window: assert property (@(posedge clk) disable iff (rst)
    step && res.timer_irq |=> reload_window_active && ticks_after_reload == 3'd0)
    else $error("reload did not open the TIMA write window");

  a_irq_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    res.timer_irq |-> req.operation == dtm_pkg::OP_TICK && reload_pending)
    else $error("interrupt outside a pending reload tick");

  a_pending_count: assert property (@(posedge clk) disable iff (rst)
    reload_pending |-> ticks_since_overflow < dtm_pkg::WINDOW_TICKS)
    else $error("overflow delay ran past four ticks");

  a_window_count: assert property (@(posedge clk) disable iff (rst)
    reload_window_active |-> ticks_after_reload < dtm_pkg::WINDOW_TICKS)
    else $error("reload window ran past four ticks");

  a_sel_follows_enable: assert property (@(posedge clk) disable iff (rst)
    !timer_control[2] |-> !previous_selected_bit)
    else $error("selector output high while timer disabled");

endmodule

/* test/divider_timer_with_modulo_reload_tb.sv */
// ----------------------------------------------------------------------------
// divider_timer_with_modulo_reload_tb - self-checking bench for the DIV/TIMA timer
// A clocked driver sends tick, read and write requests from a queue. A clocked
// monitor mirrors the timer state for every accepted request and checks each
// returned byte and interrupt flag in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module divider_timer_with_modulo_reload_tb;

  // Operation code 3 has no meaning; the block must answer it as idle.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         ITEM_TARGET = 650;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         MAX_PRINTS   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = dtm_pkg::OP_TICK;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_data;
  logic        timer_irq;

  divider_timer_with_modulo_reload DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .address    (address),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data),
    .timer_irq  (timer_irq)
  );

  // Requests waiting to be driven, and replies the timer must still return.
  dtm_pkg::req_t bus_requests[$];
  dtm_pkg::res_t timer_replies[$];

  int mismatches   = 0;
  int live_items   = 0;
  int replies_seen = 0;
  int n_ticks = 0, n_reads = 0, n_writes = 0, n_reloads = 0;

  // Mirror of the timer state. Names follow the register they shadow.
  logic [15:0] div_count    = '0;  // 16-bit system counter, DIV is the top byte
  logic [7:0]  tima_q       = '0;
  logic [7:0]  tma_q        = '0;
  logic [2:0]  tac_q        = '0;
  logic        tap_prev     = 1'b0;  // last selector output seen by edge detect
  logic        reload_armed = 1'b0;  // TIMA overflowed, reload not yet done
  logic [2:0]  ovf_age      = '0;
  logic        guard_open   = 1'b0;  // four ticks after a reload
  logic [2:0]  guard_age    = '0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting: one line per failure, printing capped, all counted.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] MISMATCH reply %0d: %s", $realtime, replies_seen, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Timer mirror
  // ---------------------------------------------------------------------------
  // TAC[1:0] picks counter bit 9, 3, 5 or 7.
  function automatic logic counter_tap(input logic [15:0] cnt, input logic [1:0] sel);
    logic b;
    case (sel)
      2'd0:    b = cnt[9];
      2'd1:    b = cnt[3];
      2'd2:    b = cnt[5];
      default: b = cnt[7];
    endcase
    return b;
  endfunction

  // TIMA +1; wrapping to zero arms the delayed reload.
  task automatic tima_inc();
    tima_q = tima_q + 8'd1;
    if (tima_q == 8'd0) begin
      reload_armed = 1'b1;
      ovf_age      = '0;
    end
  endtask

  // Falling edge of the selector output bumps TIMA.
  task automatic tap_update(input logic tap_now);
    if (tap_prev && !tap_now)
      tima_inc();
    tap_prev = tap_now;
  endtask

  task automatic set_div_count(input logic [15:0] value);
    div_count = value;
    tap_update(counter_tap(div_count, tac_q[1:0]) && tac_q[2]);
  endtask

  // Applies one accepted request to the mirror and returns the expected reply.
  task automatic advance_timer(input dtm_pkg::req_t rq, output dtm_pkg::res_t reply);
    logic old_tap;
    logic tac_en;
    reply.read_data = dtm_pkg::IDLE_READ;
    reply.timer_irq = 1'b0;
    case (rq.operation)
      dtm_pkg::OP_TICK: begin
        n_ticks++;
        // age the post-reload window first, then the pending reload
        if (guard_open) begin
          guard_age = guard_age + 3'd1;
          if (guard_age == dtm_pkg::WINDOW_TICKS)
            guard_open = 1'b0;
        end
        if (reload_armed) begin
          ovf_age = ovf_age + 3'd1;
          if (ovf_age == dtm_pkg::WINDOW_TICKS) begin
            tima_q          = tma_q;
            reload_armed    = 1'b0;
            reply.timer_irq = 1'b1;
            guard_open      = 1'b1;
            guard_age       = '0;
            n_reloads++;
          end
        end
        set_div_count(div_count + 16'd1);
      end
      dtm_pkg::OP_READ: begin
        n_reads++;
        case (rq.address)
          dtm_pkg::ADDR_DIV:  reply.read_data = div_count[15:8];
          dtm_pkg::ADDR_TIMA: reply.read_data = tima_q;
          dtm_pkg::ADDR_TMA:  reply.read_data = tma_q;
          dtm_pkg::ADDR_TAC:  reply.read_data = {5'd0, tac_q} | dtm_pkg::TAC_READ_ONES;
          default:            reply.read_data = dtm_pkg::IDLE_READ;
        endcase
      end
      dtm_pkg::OP_WRITE: begin
        n_writes++;
        case (rq.address)
          dtm_pkg::ADDR_DIV: set_div_count('0);
          dtm_pkg::ADDR_TIMA: begin
            // ignored while the reload window is open, else cancels a reload
            if (!guard_open) begin
              tima_q       = rq.write_data;
              reload_armed = 1'b0;
              ovf_age      = '0;
            end
          end
          dtm_pkg::ADDR_TMA: begin
            tma_q = rq.write_data;
            if (guard_open)
              tima_q = rq.write_data;
          end
          dtm_pkg::ADDR_TAC: begin
            // selector output becomes old output AND new enable
            old_tap = tap_prev;
            tac_en  = rq.write_data[2];
            tap_update(old_tap && tac_en);
            if (!old_tap && tac_en && counter_tap(div_count, rq.write_data[1:0]))
              tima_inc();
            tac_q = rq.write_data[2:0];
          end
          default: ;
        endcase
      end
      default: ;  // unused code: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, a few long, and calm stretches with
  // no idling at all.
  // ---------------------------------------------------------------------------
  function automatic int idle_span(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents requests at the falling edge, holds them until taken.
  // ---------------------------------------------------------------------------
  logic req_accepted = 1'b0;  // set by the monitor at each rising edge
  int   send_gap  = 0;
  int   send_calm = 0;

  always @(negedge clk) begin : drive_requests
    dtm_pkg::req_t rq;
    if (!rst) begin
      if (!in_valid || req_accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bus_requests.size() > 0) begin
          rq = bus_requests.pop_front();
          operation  <= rq.operation;
          address    <= rq.address;
          write_data <= rq.write_data;
          in_valid   <= 1'b1;
          send_gap = idle_span(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result-side back-pressure, also changed at the falling edge.
  int stall_left = 0;
  int stall_calm = 0;

  always @(negedge clk) begin : drive_stall
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = idle_span(stall_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each accepted request, checks each accepted reply.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_bus
    dtm_pkg::req_t rq;
    dtm_pkg::res_t want;
    req_accepted = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        rq.operation  = operation;
        rq.address    = address;
        rq.write_data = write_data;
        advance_timer(rq, want);
        timer_replies.push_back(want);
        req_accepted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        if (timer_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected reply data=%h irq=%b", read_data, timer_irq));
        end else begin
          want = timer_replies.pop_front();
          if (read_data !== want.read_data)
            report_mismatch($sformatf("read_data expected %h got %h",
                                      want.read_data, read_data));
          if (timer_irq !== want.timer_irq)
            report_mismatch($sformatf("timer_irq expected %b got %b",
                                      want.timer_irq, timer_irq));
        end
        replies_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_request(input logic [1:0] op, input logic [15:0] adr,
                             input logic [7:0] dat);
    dtm_pkg::req_t rq;
    rq.operation  = op;
    rq.address    = adr;
    rq.write_data = dat;
    bus_requests.push_back(rq);
    // unused codes and unmapped writes leave the timer untouched
    if (op != OP_UNUSED && !(op == dtm_pkg::OP_WRITE &&
        (adr < dtm_pkg::ADDR_DIV || adr > dtm_pkg::ADDR_TAC)))
      live_items++;
  endtask

  function automatic logic [15:0] timer_reg();
    return dtm_pkg::ADDR_DIV + 16'($urandom_range(0, 3));
  endfunction

  initial begin : main_flow
    int   steps;
    int   r;
    logic [7:0] tac_byte;

    // --- directed opening ---
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_DIV,  8'h00);
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_TAC,  8'h00);
    add_request(OP_UNUSED, 16'hFFFF, 8'hFF);                 // unused operation code
    add_request(dtm_pkg::OP_WRITE, 16'h0000, 8'h00);         // unmapped write, ignored
    add_request(dtm_pkg::OP_READ,  16'hFF03, 8'h00);         // unmapped read
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TMA,  8'h5A);
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TIMA, 8'hFF);
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TAC,  8'hFD);  // junk upper bits, bit 3
    repeat (8) add_request(dtm_pkg::OP_TICK, 16'h0000, 8'h00);  // counter bit 3 goes high
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_DIV,  8'h00);  // DIV clear: overflow
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_TIMA, 8'h00);  // zero while reload pends
    repeat (3) add_request(dtm_pkg::OP_TICK, 16'h0000, 8'h00);
    add_request(dtm_pkg::OP_TICK,  16'hFFFF, 8'hFF);            // reload from TMA, interrupt
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TIMA, 8'h00);  // ignored inside the window
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TMA,  8'hFF);  // also loads TIMA
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_TIMA, 8'h00);
    repeat (4) add_request(dtm_pkg::OP_TICK, 16'h0000, 8'h00);  // window closes, bit 3 high
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TAC,  8'h01);  // disable: overflow
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TIMA, 8'h00);  // cancels the reload
    add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TAC,  8'h05);  // enable, tap set: +1
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_TIMA, 8'h00);
    add_request(dtm_pkg::OP_READ,  dtm_pkg::ADDR_TAC,  8'h00);

    // --- random part ---
    while (live_items < ITEM_TARGET) begin
      if ($urandom_range(0, 3) != 0) begin
        // Overflow run: TIMA near the top, fast tap mostly, then mostly ticks
        // with reads and writes scattered so some land in the reload windows.
        tac_byte    = 8'($urandom);
        tac_byte[2] = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 1) == 1)
          tac_byte[1:0] = 2'd1;
        add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TMA,  8'($urandom));
        add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TAC,  tac_byte);
        add_request(dtm_pkg::OP_WRITE, dtm_pkg::ADDR_TIMA, 8'hFC | 8'($urandom_range(0, 3)));
        steps = $urandom_range(20, 70);
        repeat (steps) begin
          r = $urandom_range(0, 99);
          if (r < 64)
            add_request(dtm_pkg::OP_TICK, 16'($urandom), 8'($urandom));
          else if (r < 80)
            add_request(dtm_pkg::OP_READ, timer_reg(), 8'($urandom));
          else if (r < 96)
            add_request(dtm_pkg::OP_WRITE, timer_reg(), 8'($urandom));
          else
            add_request(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
      end else begin
        // noise: any code, any address
        steps = $urandom_range(4, 12);
        repeat (steps) begin
          add_request(2'($urandom_range(0, 3)),
                      ($urandom_range(0, 1) == 1) ? timer_reg() : 16'($urandom),
                      8'($urandom));
        end
      end
    end

    // --- reset once, released at a falling edge ---
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all requests taken, all replies back, then a short drain for strays
    while (bus_requests.size() != 0 || in_valid)
      @(posedge clk);
    while (timer_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d ticks, %0d reads, %0d writes; %0d reloads raised the interrupt.",
             n_ticks, n_reads, n_writes, n_reloads);
    $display("%0d replies checked, %0d mismatches.", replies_seen, mismatches);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d requests left, %0d replies outstanding.",
             bus_requests.size(), timer_replies.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
